// File: src/ancs_pkg.sv
`default_nettype none
package ancs_pkg;

  // Unit counter width default (saturating counter)
  localparam int UNIT_COUNT_BITS_DEF = 16;

  // Most words one input byte can release, and depth of the result queue
  localparam int MAX_RES   = 5;
  localparam int QDEPTH    = 8;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);
  localparam int RES_BITS  = $clog2(MAX_RES + 1);
  localparam int RIDX_BITS = $clog2(MAX_RES);

  // Held byte window
  localparam int WIN_DEPTH = 4;

  // Start code bytes
  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_ONE  = 8'h01;

  // Raw nal_unit_type codes
  localparam logic [4:0] NAL_NON_IDR = 5'd1;
  localparam logic [4:0] NAL_IDR     = 5'd5;
  localparam logic [4:0] NAL_SEI     = 5'd6;
  localparam logic [4:0] NAL_SPS     = 5'd7;
  localparam logic [4:0] NAL_PPS     = 5'd8;
  localparam logic [4:0] NAL_AUD     = 5'd9;

  // Type class codes
  localparam logic [2:0] CLS_NON_IDR = 3'd0;
  localparam logic [2:0] CLS_IDR     = 3'd1;
  localparam logic [2:0] CLS_SEI     = 3'd2;
  localparam logic [2:0] CLS_SPS     = 3'd3;
  localparam logic [2:0] CLS_PPS     = 3'd4;
  localparam logic [2:0] CLS_AUD     = 3'd5;
  localparam logic [2:0] CLS_UNKNOWN = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        unit_first;
    logic        unit_last;
    logic        forbidden_error;
    logic [1:0]  priority_nri;
    logic [4:0]  unit_type;
    logic [2:0]  type_class;
    logic [15:0] unit_number;
  } out_word_t;

  // Words released by one input byte, in order, plus their count
  typedef struct packed {
    logic [RES_BITS-1:0]     cnt;
    out_word_t [MAX_RES-1:0] item;
  } burst_t;

  function automatic logic [2:0] class_of(input logic [4:0] t);
    logic [2:0] c;
    case (t)
      NAL_NON_IDR: c = CLS_NON_IDR;
      NAL_IDR:     c = CLS_IDR;
      NAL_SEI:     c = CLS_SEI;
      NAL_SPS:     c = CLS_SPS;
      NAL_PPS:     c = CLS_PPS;
      NAL_AUD:     c = CLS_AUD;
      default:     c = CLS_UNKNOWN;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: src/ancs_parse.sv
`default_nettype none
module ancs_parse #(
  parameter int UNIT_COUNT_BITS = ancs_pkg::UNIT_COUNT_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire ancs_pkg::in_word_t in_word,
  output ancs_pkg::burst_t       burst
);

  localparam logic [UNIT_COUNT_BITS-1:0] CNT_MAX = '1;

  // Scanner state
  logic [ancs_pkg::WIN_DEPTH-1:0][7:0] win_r, win_nxt;
  logic [2:0]                          held_r, held_nxt;
  logic                                inside_r, inside_nxt;
  logic                                pending_r, pending_nxt;
  logic [7:0]                          latched_r, latched_nxt;
  logic [UNIT_COUNT_BITS-1:0]          ucnt_r, ucnt_nxt;

  logic [2:0]                          h;
  logic [ancs_pkg::WIN_DEPTH:0][7:0]   tmp;
  logic                                sc, strip4, is_end, emit, last_flag;
  logic [ancs_pkg::RES_BITS-1:0]       raw_cnt, cnt;
  logic [7:0]                          hdr;
  logic [UNIT_COUNT_BITS-1:0]          ucnt_inc;

  // Window plus new byte, start code detection, release count
  always_comb begin
    h = (held_r > 3'd4) ? 3'd4 : held_r;
    for (int i = 0; i < ancs_pkg::WIN_DEPTH; i++) begin
      if (3'(i) < h) begin
        tmp[i] = win_r[i];
      end else if (3'(i) == h) begin
        tmp[i] = in_word.data_byte;
      end else begin
        tmp[i] = ancs_pkg::SC_ZERO;
      end
    end
    tmp[ancs_pkg::WIN_DEPTH] = in_word.data_byte;
    is_end = in_word.stream_end;

    sc     = 1'b0;
    strip4 = 1'b0;
    case (h)
      3'd2: begin
        sc = (win_r[0] == ancs_pkg::SC_ZERO) && (win_r[1] == ancs_pkg::SC_ZERO);
      end
      3'd3: begin
        sc     = (win_r[1] == ancs_pkg::SC_ZERO) && (win_r[2] == ancs_pkg::SC_ZERO);
        strip4 = (win_r[0] == ancs_pkg::SC_ZERO);
      end
      3'd4: begin
        sc     = (win_r[2] == ancs_pkg::SC_ZERO) && (win_r[3] == ancs_pkg::SC_ZERO);
        strip4 = (win_r[1] == ancs_pkg::SC_ZERO);
      end
      default: begin
        sc     = 1'b0;
        strip4 = 1'b0;
      end
    endcase
    sc = sc && (in_word.data_byte == ancs_pkg::SC_ONE);

    if (sc) begin
      raw_cnt = strip4 ? ancs_pkg::RES_BITS'(h - 3'd3) : ancs_pkg::RES_BITS'(h - 3'd2);
    end else if (is_end) begin
      raw_cnt = ancs_pkg::RES_BITS'(h) + 1'b1;
    end else if (h == 3'd4) begin
      raw_cnt = ancs_pkg::RES_BITS'(1);
    end else begin
      raw_cnt = '0;
    end
    last_flag = sc || is_end;
    cnt       = inside_r ? raw_cnt : '0;
    emit      = (cnt != '0);
    hdr       = pending_r ? tmp[0] : latched_r;
    // unit number carried by this byte's words, before any stream-end clear
    ucnt_inc  = (pending_r && emit && (ucnt_r != CNT_MAX)) ? ucnt_r + 1'b1 : ucnt_r;
  end

  // Next state
  always_comb begin
    win_nxt     = win_r;
    held_nxt    = held_r;
    inside_nxt  = inside_r;
    pending_nxt = pending_r && !emit;
    latched_nxt = (pending_r && emit) ? tmp[0] : latched_r;
    ucnt_nxt    = ucnt_inc;
    if (sc && !is_end) begin
      inside_nxt  = 1'b1;
      pending_nxt = 1'b1;
      held_nxt    = 3'd0;
      win_nxt     = '0;
    end else if (is_end) begin
      inside_nxt  = 1'b0;
      pending_nxt = 1'b0;
      held_nxt    = 3'd0;
      win_nxt     = '0;
      latched_nxt = '0;
      ucnt_nxt    = '0;
    end else if (h == 3'd4) begin
      for (int i = 0; i < ancs_pkg::WIN_DEPTH; i++) begin
        win_nxt[i] = tmp[i+1];
      end
      held_nxt = 3'd4;
    end else begin
      for (int i = 0; i < ancs_pkg::WIN_DEPTH; i++) begin
        win_nxt[i] = tmp[i];
      end
      held_nxt = h + 3'd1;
    end
  end

  // Released words; all share this unit's header and number
  always_comb begin
    burst.cnt = cnt;
    for (int j = 0; j < ancs_pkg::MAX_RES; j++) begin
      burst.item[j].payload_byte    = tmp[j];
      burst.item[j].unit_first      = pending_r && (j == 0);
      burst.item[j].unit_last       = last_flag && (ancs_pkg::RES_BITS'(j + 1) == cnt);
      burst.item[j].forbidden_error = hdr[7];
      burst.item[j].priority_nri    = hdr[6:5];
      burst.item[j].unit_type       = hdr[4:0];
      burst.item[j].type_class      = ancs_pkg::class_of(hdr[4:0]);
      burst.item[j].unit_number     = 16'(ucnt_inc);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r    <= 3'd0;
      inside_r  <= 1'b0;
      pending_r <= 1'b0;
      ucnt_r    <= '0;
    end else if (accept) begin
      held_r    <= held_nxt;
      inside_r  <= inside_nxt;
      pending_r <= pending_nxt;
      ucnt_r    <= ucnt_nxt;
    end
  end

  // Held bytes and latched header
  always_ff @(posedge clk) begin
    if (accept) begin
      win_r     <= win_nxt;
      latched_r <= latched_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/ancs_outq.sv
`default_nettype none
module ancs_outq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire ancs_pkg::burst_t    burst,
  output logic                     room,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ancs_pkg::out_word_t      out_data
);

  ancs_pkg::out_word_t                 mem_r [ancs_pkg::QDEPTH];
  logic [ancs_pkg::QPTR_BITS-1:0]      wr_r, wr_nxt, rd_r, rd_nxt;
  logic [ancs_pkg::QCNT_BITS-1:0]      count_r, count_nxt;
  logic [ancs_pkg::RES_BITS-1:0]       push_n;
  logic                                pop;

  // Status and pointer arithmetic
  always_comb begin
    room      = (count_r <= ancs_pkg::QCNT_BITS'(ancs_pkg::QDEPTH - ancs_pkg::MAX_RES));
    out_valid = (count_r != '0);
    out_data  = mem_r[rd_r];
    pop       = out_valid && out_ready;
    push_n    = push ? burst.cnt : '0;
    wr_nxt    = wr_r + ancs_pkg::QPTR_BITS'(push_n);
    rd_nxt    = rd_r + ancs_pkg::QPTR_BITS'(pop);
    count_nxt = count_r + ancs_pkg::QCNT_BITS'(push_n) - ancs_pkg::QCNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  // Up to MAX_RES words land at consecutive slots from the write pointer
  always_ff @(posedge clk) begin
    for (int k = 0; k < ancs_pkg::QDEPTH; k++) begin
      logic [ancs_pkg::QPTR_BITS-1:0] off;
      off = ancs_pkg::QPTR_BITS'(k) - wr_r;
      if (ancs_pkg::RES_BITS'(off) < push_n && off < ancs_pkg::QPTR_BITS'(ancs_pkg::MAX_RES)) begin
        mem_r[k] <= burst.item[ancs_pkg::RIDX_BITS'(off)];
      end
    end
  end

endmodule
`default_nettype wire

// File: src/annexb_start_code_nal_splitter_core.sv
`default_nettype none
// Channel   Ports                           Word
// input     in_valid / in_ready / in_data   data_byte, stream_end
// result    out_valid / out_ready / out_data payload byte, marks, header fields, unit number
//
// One stream byte is taken per clock while input is not stalled, and the words it releases
// enter the queue as it is accepted. A start code or stream end releases up to five words
// at once into an 8-word result queue, which drains one word per clock while out_ready is
// high; input stalls while fewer than five slots are free. Reset (synchronous, rst_n low)
// empties the queue and returns the scanner to searching for the first start code.
module annexb_start_code_nal_splitter_core #(
  parameter int UNIT_COUNT_BITS = ancs_pkg::UNIT_COUNT_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ancs_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ancs_pkg::out_word_t      out_data
);

  ancs_pkg::burst_t burst;
  logic             accept;

  assign accept = in_valid && in_ready;

  // Start code scan and unit tracking
  ancs_parse #(
    .UNIT_COUNT_BITS(UNIT_COUNT_BITS)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_word (in_data),
    .burst   (burst)
  );

  // Result queue
  ancs_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .burst     (burst),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: bench/tb_annexb_start_code_nal_splitter_core.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_annexb_start_code_nal_splitter_core;

  localparam int IDLE_LIMIT  = 2000;
  localparam int ITEM_TARGET = 320;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  ancs_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ancs_pkg::out_word_t out_data;

  annexb_start_code_nal_splitter_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Scanner mirror
  logic [7:0]  scan_win [4];
  int          scan_held;
  bit          scan_in_unit;
  bit          scan_hdr_pend;
  logic [7:0]  scan_hdr;
  logic [15:0] scan_unit_cnt;

  ancs_pkg::out_word_t nal_bytes_due [$];
  int          mismatch_cnt = 0;
  int          words_sent = 0;
  int          idle_cycles = 0;
  bit          calm = 1'b0;
  int unsigned ready_hold = 0;

  function automatic void clear_scanner();
    int i;
    for (i = 0; i < 4; i++) scan_win[i] = 8'h00;
    scan_held     = 0;
    scan_in_unit  = 1'b0;
    scan_hdr_pend = 1'b0;
    scan_hdr      = 8'h00;
    scan_unit_cnt = '0;
  endfunction

  function automatic logic [2:0] nal_class(input logic [4:0] t);
    logic [2:0] c;
    case (t)
      ancs_pkg::NAL_NON_IDR: c = ancs_pkg::CLS_NON_IDR;
      ancs_pkg::NAL_IDR:     c = ancs_pkg::CLS_IDR;
      ancs_pkg::NAL_SEI:     c = ancs_pkg::CLS_SEI;
      ancs_pkg::NAL_SPS:     c = ancs_pkg::CLS_SPS;
      ancs_pkg::NAL_PPS:     c = ancs_pkg::CLS_PPS;
      ancs_pkg::NAL_AUD:     c = ancs_pkg::CLS_AUD;
      default:               c = ancs_pkg::CLS_UNKNOWN;
    endcase
    return c;
  endfunction

  // One unit byte leaves the window; dropped while no unit is open
  function automatic void emit_nal_byte(input logic [7:0] b, input bit is_last);
    ancs_pkg::out_word_t o;
    if (!scan_in_unit) return;
    o.unit_first = 1'b0;
    if (scan_hdr_pend) begin
      scan_hdr      = b;
      scan_hdr_pend = 1'b0;
      if (scan_unit_cnt != 16'hFFFF) scan_unit_cnt++;
      o.unit_first  = 1'b1;
    end
    o.payload_byte    = b;
    o.unit_last       = is_last;
    o.forbidden_error = scan_hdr[7];
    o.priority_nri    = scan_hdr[6:5];
    o.unit_type       = scan_hdr[4:0];
    o.type_class      = nal_class(scan_hdr[4:0]);
    o.unit_number     = scan_unit_cnt;
    nal_bytes_due.push_back(o);
  endfunction

  // Advance the scanner by one stream byte, queueing the words it releases
  function automatic void split_stream_byte(input ancs_pkg::in_word_t w);
    logic [7:0] pend [5];
    int n, keep, strip, i;
    n = scan_held;
    for (i = 0; i < n; i++) pend[i] = scan_win[i];
    pend[n] = w.data_byte;
    n++;
    if (w.data_byte == ancs_pkg::SC_ONE && n >= 3 && pend[n-2] == ancs_pkg::SC_ZERO &&
        pend[n-3] == ancs_pkg::SC_ZERO) begin
      // start code: close the open unit, at most three zeros stripped
      strip = (n >= 4 && pend[n-4] == ancs_pkg::SC_ZERO) ? 4 : 3;
      keep  = n - strip;
      for (i = 0; i < keep; i++) emit_nal_byte(pend[i], i == keep - 1);
      scan_in_unit  = 1'b1;
      scan_hdr_pend = 1'b1;
      scan_held     = 0;
      if (w.stream_end) clear_scanner();
    end else if (w.stream_end) begin
      for (i = 0; i < n; i++) emit_nal_byte(pend[i], i == n - 1);
      clear_scanner();
    end else if (n == 5) begin
      emit_nal_byte(pend[0], 1'b0);
      for (i = 0; i < 4; i++) scan_win[i] = pend[i+1];
      scan_held = 4;
    end else begin
      for (i = 0; i < n; i++) scan_win[i] = pend[i];
      scan_held = n;
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result check and prediction, both on pre-edge values
  always @(posedge clk) begin
    ancs_pkg::out_word_t want;
    if (rst_n) begin
      if (out_valid === 1'b1 && out_ready) begin
        if (nal_bytes_due.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual 0x%0h", $time, out_data);
          mismatch_cnt++;
        end else begin
          want = nal_bytes_due.pop_front();
          check_field("payload_byte", want.payload_byte, out_data.payload_byte);
          check_field("unit_first", want.unit_first, out_data.unit_first);
          check_field("unit_last", want.unit_last, out_data.unit_last);
          check_field("forbidden_error", want.forbidden_error, out_data.forbidden_error);
          check_field("priority_nri", want.priority_nri, out_data.priority_nri);
          check_field("unit_type", want.unit_type, out_data.unit_type);
          check_field("type_class", want.type_class, out_data.type_class);
          check_field("unit_number", want.unit_number, out_data.unit_number);
        end
      end
      if (in_valid && in_ready === 1'b1) split_stream_byte(in_data);
    end
  end

  // Result side stalls
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      ready_hold <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d words still expected", $time, nal_bytes_due.size());
      $display("** annexb_start_code_nal_splitter_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(input logic [7:0] b, input logic is_end);
    ancs_pkg::in_word_t w;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w.data_byte  = b;
    w.stream_end = is_end;
    in_data  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    words_sent++;
  endtask

  function automatic logic [7:0] pick_header();
    logic [4:0] t;
    case ($urandom_range(0, 7))
      0: t = ancs_pkg::NAL_NON_IDR;
      1: t = ancs_pkg::NAL_IDR;
      2: t = ancs_pkg::NAL_SEI;
      3: t = ancs_pkg::NAL_SPS;
      4: t = ancs_pkg::NAL_PPS;
      5: t = ancs_pkg::NAL_AUD;
      default: t = 5'($urandom_range(0, 31));
    endcase
    return {($urandom_range(0, 7) == 0), 2'($urandom_range(0, 3)), t};
  endfunction

  // Payload bytes lean toward zeros and start code pieces
  function automatic logic [7:0] pick_body_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return ancs_pkg::SC_ZERO;
    if (r < 30) return ancs_pkg::SC_ONE;
    if (r < 35) return 8'h03;
    return 8'($urandom_range(0, 255));
  endfunction

  // One start code (3 or 4 bytes, sometimes extra zeros) then, unless empty, header and body
  task automatic send_nal_unit(input int max_len);
    int zeros, len, i;
    bit empty_unit, ends_here;
    zeros = ($urandom_range(0, 2) == 0) ? 3 : 2;
    if ($urandom_range(0, 9) == 0) zeros += $urandom_range(1, 2);
    empty_unit = ($urandom_range(0, 14) == 0);
    ends_here  = ($urandom_range(0, 11) == 0);
    for (i = 0; i < zeros; i++) send_word(ancs_pkg::SC_ZERO, 1'b0);
    if (empty_unit) begin
      send_word(ancs_pkg::SC_ONE, ends_here);
    end else begin
      send_word(ancs_pkg::SC_ONE, 1'b0);
      len = $urandom_range(0, max_len);
      send_word(pick_header(), ends_here && len == 0);
      for (i = 0; i < len; i++) send_word(pick_body_byte(), ends_here && i == len - 1);
    end
  endtask

  task automatic test_directed_stream();
    calm = 1'b1;
    // junk before the first start code is dropped
    send_word(8'h55, 1'b0);
    send_word(8'hFF, 1'b0);
    // 3-byte code, SPS unit
    send_word(ancs_pkg::SC_ZERO, 1'b0); send_word(ancs_pkg::SC_ZERO, 1'b0);
    send_word(ancs_pkg::SC_ONE, 1'b0);
    send_word(8'h67, 1'b0);
    send_word(8'hAA, 1'b0);
    // 4-byte code, then a second code right after: empty unit
    send_word(ancs_pkg::SC_ZERO, 1'b0); send_word(ancs_pkg::SC_ZERO, 1'b0);
    send_word(ancs_pkg::SC_ZERO, 1'b0); send_word(ancs_pkg::SC_ONE, 1'b0);
    send_word(ancs_pkg::SC_ZERO, 1'b0); send_word(ancs_pkg::SC_ZERO, 1'b0);
    send_word(ancs_pkg::SC_ONE, 1'b0);
    // forbidden bit set, IDR; four zeros before the code leave one as payload
    calm = 1'b0;
    send_word(8'hE5, 1'b0);
    send_word(ancs_pkg::SC_ZERO, 1'b0); send_word(ancs_pkg::SC_ZERO, 1'b0);
    send_word(ancs_pkg::SC_ZERO, 1'b0); send_word(ancs_pkg::SC_ZERO, 1'b0);
    send_word(ancs_pkg::SC_ONE, 1'b0);
    // one-byte SEI unit closed by stream end
    send_word(8'h06, 1'b1);
    // start code as the very last bytes of a stream
    send_word(ancs_pkg::SC_ZERO, 1'b0); send_word(ancs_pkg::SC_ZERO, 1'b0);
    send_word(ancs_pkg::SC_ONE, 1'b1);
  endtask

  task automatic test_noise_bytes(input int count);
    int i;
    for (i = 0; i < count; i++)
      send_word(pick_body_byte(), $urandom_range(0, 9) == 0);
  endtask

  task automatic test_random_units(input int target);
    while (words_sent < target) begin
      if ($urandom_range(0, 5) == 0) calm = ~calm;
      send_nal_unit(($urandom_range(0, 9) == 0) ? 40 : 10);
    end
    calm = 1'b0;
  endtask

  // Sender holds off until every released word has drained
  task automatic test_drain_pause();
    send_nal_unit(12);
    in_valid <= 1'b0;
    // let the last accepted byte reach the predictor first
    @(posedge clk);
    while (nal_bytes_due.size() != 0) @(posedge clk);
    send_nal_unit(6);
  endtask

  initial begin
    clear_scanner();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_stream();
    test_noise_bytes(30);
    test_random_units(ITEM_TARGET * 2 / 3);
    test_drain_pause();
    test_random_units(ITEM_TARGET);

    in_valid <= 1'b0;
    while (nal_bytes_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (nal_bytes_due.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, nal_bytes_due.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("** annexb_start_code_nal_splitter_core: PASSED **");
    end else begin
      $display("** annexb_start_code_nal_splitter_core: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
src/ancs_pkg.sv
src/ancs_parse.sv
src/ancs_outq.sv
src/annexb_start_code_nal_splitter_core.sv
bench/tb_annexb_start_code_nal_splitter_core.sv
